FILE: rtl/can_acceptance_filter_bank_core_defines.svh
// ----------------------------------------------------------------------------
// can acceptance filter bank: assertion macros
// checks on clk, with and without the reset disable
// ----------------------------------------------------------------------------
`ifndef CAN_ACCEPTANCE_FILTER_BANK_CORE_DEFINES_SVH
`define CAN_ACCEPTANCE_FILTER_BANK_CORE_DEFINES_SVH

// property checked while out of reset
`define CAFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also holds across reset
`define CAFB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cafb_pkg.sv
// ----------------------------------------------------------------------------
// cafb_pkg
// shared types and constants of the can acceptance filter bank
// ----------------------------------------------------------------------------
`default_nettype none

package cafb_pkg;

    localparam int unsigned ID_W      = 12;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned CNT_REGS  = 3;
    localparam logic [11:0] RTR_BIT   = 12'h800;
    localparam logic [3:0]  MAX_DLC   = 4'd8;

    typedef enum logic [2:0] {
        STAT_DELIVERED = 3'd0,
        STAT_NO_MATCH  = 3'd1,
        STAT_INACTIVE  = 3'd2,
        STAT_REJECTED  = 3'd3,
        STAT_WRITTEN   = 3'd4,
        STAT_WR_REJ    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_BUS_ONLINE = 3'd0,
        REG_PORT_ACT   = 3'd1,
        REG_ENTRIES0   = 3'd2,
        REG_ENTRIES1   = 3'd3,
        REG_ENTRIES2   = 3'd4
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PORT = 5'b00010,
        ST_READ = 5'b00100,
        ST_CMP  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/can_acceptance_filter_bank_core.sv
// write request: result valid in the cycle after accept, then held until out_ready
// frame request: per port a decide state, then for each filter entry scanned
//   one memory read and one compare on a single comparator, then an output
//   state held until out_ready; one request at a time
// reset: async; resets control, config and all filter valid bits at once
// ----------------------------------------------------------------------------
// can_acceptance_filter_bank_core
// per-port id/mask acceptance filters, scanned by one shared comparator
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_acceptance_filter_bank_core_defines.svh"

module can_acceptance_filter_bank_core
    import cafb_pkg::*;
#(
    parameter int PORTS   = 3,
    parameter int FILTERS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [4:0]  cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [1:0]  port,
    input  wire logic [3:0]  entry_index,
    input  wire logic [10:0] filter_id,
    input  wire logic [10:0] filter_mask,
    input  wire logic        filter_rtr,
    input  wire logic [11:0] frame_ident,
    input  wire logic [3:0]  frame_length,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_port,
    output logic [2:0]       status,
    output logic [3:0]       hit_entry,
    output logic             last
);

    // only the ports with a count register can ever hold entries
    localparam int ACT_PORTS = (PORTS < CNT_REGS) ? PORTS : CNT_REGS;
    localparam int DEPTH     = ACT_PORTS * FILTERS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PCW       = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int IW        = (FILTERS > 1) ? $clog2(FILTERS) : 1;
    localparam int NW        = $clog2(FILTERS + 1);

    // configuration
    logic                 bus_online_reg;
    logic [2:0]           port_active_reg;
    logic [CNT_W-1:0]     entries_reg [CNT_REGS];

    // sequencer
    state_t               state_reg, state_next;
    logic [PCW-1:0]       port_reg, port_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic [ID_W-1:0]      ident_reg, ident_next;
    logic                 reject_reg, reject_next;

    // result register
    logic [1:0]           res_port_reg, res_port_next;
    status_t              status_reg, status_next;
    logic [3:0]           hit_reg, hit_next;
    logic                 last_reg, last_next;

    // filter store
    logic [2*ID_W-1:0]    filt_mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [2*ID_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;

    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;
    logic                 wr_ok;
    logic [NW-1:0]        wr_cnt;
    logic [NW-1:0]        scan_cnt;
    logic                 scan_act;
    logic [7:0]           port_ext;
    logic [3:0]           act_vec;
    logic                 match;
    logic                 in_acc;

    function automatic logic [NW-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [6:0] ext;
        ext = 7'(c);
        if (ext > 7'(FILTERS))
            return NW'(FILTERS);
        else
            return NW'(ext);
    endfunction

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_acc      = in_valid && in_ready;
    assign out_valid   = (state_reg == ST_OUT);
    assign result_port = res_port_reg;
    assign status      = status_reg;
    assign hit_entry   = hit_reg;
    assign last        = last_reg;

    // entry count of the port named by a write
    always_comb
    begin
        case (port)
            2'd0:    wr_cnt = sat_count(entries_reg[0]);
            2'd1:    wr_cnt = sat_count(entries_reg[1]);
            2'd2:    wr_cnt = sat_count(entries_reg[2]);
            default: wr_cnt = '0;
        endcase
    end

    assign wr_ok   = (32'(port) < ACT_PORTS) && (8'(entry_index) < 8'(wr_cnt));
    assign wr_en   = in_acc && action && wr_ok;
    assign wr_addr = AW'(32'(port) * FILTERS + 32'(entry_index));

    // count and active bit of the port being scanned
    assign port_ext = 8'(port_reg);
    assign act_vec  = {1'b0, port_active_reg};
    assign scan_act = (port_ext < 8'(CNT_REGS)) && act_vec[port_ext[1:0]];

    always_comb
    begin
        case (port_ext)
            8'd0:    scan_cnt = sat_count(entries_reg[0]);
            8'd1:    scan_cnt = sat_count(entries_reg[1]);
            8'd2:    scan_cnt = sat_count(entries_reg[2]);
            default: scan_cnt = '0;
        endcase
    end

    assign rd_addr = AW'(32'(port_reg) * FILTERS + 32'(idx_reg));

    // the one comparator: ident in the upper half, mask in the lower half
    assign match = rd_valid_reg &&
                   (((ident_reg ^ rd_data_reg[2*ID_W-1:ID_W]) & rd_data_reg[ID_W-1:0]) == '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            filt_mem[wr_addr] <= {{1'b0, filter_id} | (filter_rtr ? RTR_BIT : '0),
                                  {1'b0, filter_mask} | RTR_BIT};
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= filt_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (state_reg == ST_READ)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_online_reg  <= 1'b1;
            port_active_reg <= '0;
            for (int k = 0; k < CNT_REGS; k++)
            begin
                entries_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BUS_ONLINE: bus_online_reg  <= cfg_data[0];
                REG_PORT_ACT:   port_active_reg <= cfg_data[2:0];
                REG_ENTRIES0:   entries_reg[0]  <= cfg_data;
                REG_ENTRIES1:   entries_reg[1]  <= cfg_data;
                REG_ENTRIES2:   entries_reg[2]  <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        port_next     = port_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        ident_next    = ident_reg;
        reject_next   = reject_reg;
        res_port_next = res_port_reg;
        status_next   = status_reg;
        hit_next      = hit_reg;
        last_next     = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action)
                    begin
                        res_port_next = port;
                        status_next   = wr_ok ? STAT_WRITTEN : STAT_WR_REJ;
                        hit_next      = '0;
                        last_next     = 1'b1;
                        state_next    = ST_OUT;
                    end
                    else
                    begin
                        ident_next  = frame_ident;
                        reject_next = !bus_online_reg || (frame_length > MAX_DLC);
                        port_next   = '0;
                        state_next  = ST_PORT;
                    end
                end
            end
            ST_PORT:
            begin
                res_port_next = 2'(port_reg);
                hit_next      = '0;
                last_next     = (32'(port_reg) == PORTS - 1);
                idx_next      = '0;
                cnt_next      = scan_cnt;
                if (reject_reg)
                begin
                    status_next = STAT_REJECTED;
                    state_next  = ST_OUT;
                end
                else if (!scan_act)
                begin
                    status_next = STAT_INACTIVE;
                    state_next  = ST_OUT;
                end
                else if (scan_cnt == '0)
                begin
                    status_next = STAT_NO_MATCH;
                    state_next  = ST_OUT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (match)
                begin
                    status_next = STAT_DELIVERED;
                    hit_next    = 4'(idx_reg);
                    state_next  = ST_OUT;
                end
                else if (8'(idx_reg) + 8'd1 == 8'(cnt_reg))
                begin
                    status_next = STAT_NO_MATCH;
                    state_next  = ST_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        port_next  = port_reg + PCW'(1);
                        state_next = ST_PORT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            port_reg  <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            port_reg  <= port_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ident_reg    <= ident_next;
        reject_reg   <= reject_next;
        res_port_reg <= res_port_next;
        status_reg   <= status_next;
        hit_reg      <= hit_next;
        last_reg     <= last_next;
    end

    `CAFB_ASSERT(a_ready_not_busy, in_ready |-> !out_valid, "ready while a result is pending")
    `CAFB_ASSERT(a_last_frees, (out_valid && out_ready && last) |=> in_ready,
                 "not ready after final result")
    `CAFB_ASSERT(a_write_result, (in_valid && in_ready && action) |=> (out_valid && last &&
                 (status == STAT_WRITTEN || status == STAT_WR_REJ)),
                 "write request gave no write result")
    `CAFB_ASSERT(a_frame_not_last, (out_valid && !last) |->
                 (status != STAT_WRITTEN && status != STAT_WR_REJ),
                 "write status on a non-final result")
    `CAFB_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid, "result right after reset")

endmodule

`default_nettype wire
